@@ sv/uap_pkg.sv @@
// Shared types and constants for the URL authority parser.
`default_nettype none

package uap_pkg;

  localparam int unsigned LEN_W  = 12;
  localparam int unsigned PORT_W = 16;

  localparam logic [LEN_W-1:0] HOST_LIMIT_RST = 12'd255;

  // one input byte as it moves from the input register to the parser
  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_last;
  } item_t;

  // one finished result
  typedef struct packed {
    logic              url_ok;
    logic [LEN_W-1:0]  scheme_len;
    logic [LEN_W-1:0]  host_len;
    logic              port_given;
    logic [PORT_W-1:0] port_number;
    logic              path_given;
    logic [LEN_W-1:0]  path_start;
  } res_t;

endpackage : uap_pkg

`default_nettype wire

@@ sv/uap_if.sv @@
// Valid/ready channel interfaces for the byte input and the result output.
`default_nettype none

interface uap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_last;

  modport source (output valid, output char_byte, output is_last, input ready);
  modport sink   (input valid, input char_byte, input is_last, output ready);
endinterface : uap_in_if

interface uap_out_if;
  logic        valid;
  logic        ready;
  logic        url_ok;
  logic [11:0] scheme_len;
  logic [11:0] host_len;
  logic        port_given;
  logic [15:0] port_number;
  logic        path_given;
  logic [11:0] path_start;

  modport source (output valid, output url_ok, output scheme_len, output host_len,
                  output port_given, output port_number, output path_given,
                  output path_start, input ready);
  modport sink   (input valid, input url_ok, input scheme_len, input host_len,
                  input port_given, input port_number, input path_given,
                  input path_start, output ready);
endinterface : uap_out_if

`default_nettype wire

@@ sv/url_authority_parser.sv @@
// URL authority parser top level: scheme://host[:port][/path] check, one byte per transaction.
// Throughput: one byte per cycle while the result register is free; a final byte waits until it can be taken.
// A result passes from the input register through the parse step into the result register,
// which drives the output channel.
// Reset: synchronous, active low; clears parse state and both valid flags and sets
// the host length limit to 255.
`default_nettype none

module url_authority_parser
  import uap_pkg::*;
#(
  parameter int unsigned MAX_URL_LEN = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [LEN_W-1:0] cfg_wdata,
  uap_in_if.sink                in_chan,
  uap_out_if.source             out_chan
);

  logic [LEN_W-1:0] host_limit_r;
  logic             item_vld;
  item_t            item;
  logic             out_free;
  logic             advance;
  res_t             res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_limit_r <= HOST_LIMIT_RST;
    end else if (cfg_we) begin
      host_limit_r <= cfg_wdata;
    end
  end

  // a non-final byte only updates parse state; the final one needs the result slot
  assign advance = item_vld && (!item.is_last || out_free);

  uap_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .advance  (advance),
    .item_vld (item_vld),
    .item     (item)
  );

  uap_parse #(
    .MAX_URL_LEN (MAX_URL_LEN)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .host_limit (host_limit_r),
    .consume    (advance),
    .item       (item),
    .res        (res)
  );

  uap_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance && item.is_last),
    .res      (res),
    .free     (out_free),
    .out_chan (out_chan)
  );

endmodule : url_authority_parser

`default_nettype wire

@@ sv/uap_in_stage.sv @@
// Input register: holds one byte transaction until the parser takes it.
`default_nettype none

module uap_in_stage
  import uap_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  uap_in_if.sink    in_chan,
  input  wire logic advance,
  output logic      item_vld,
  output item_t     item
);

  logic  vld_r;
  item_t item_r;

  assign in_chan.ready = !vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_r.char_byte <= in_chan.char_byte;
      item_r.is_last   <= in_chan.is_last;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule : uap_in_stage

`default_nettype wire

@@ sv/uap_parse.sv @@
// Per-byte parse state machine and end-of-URL result evaluation.
`default_nettype none

module uap_parse
  import uap_pkg::*;
#(
  parameter int unsigned MAX_URL_LEN = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [LEN_W-1:0] host_limit,
  input  wire logic             consume,
  input  wire item_t            item,
  output res_t                  res
);

  localparam int unsigned POS_BITS = $clog2(MAX_URL_LEN + 1);
  // never narrower than the 12-bit path offset taken from it
  localparam int unsigned POS_W = (POS_BITS > LEN_W) ? POS_BITS : LEN_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_URL_LEN);
  localparam logic [LEN_W-1:0] CNT_SAT = {LEN_W{1'b1}};
  localparam logic [16:0] PORT_SAT = 17'd65536;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    PH_SCHEME,
    PH_HOST,
    PH_PORT_START,
    PH_PORT_WS,
    PH_PORT_SIGN,
    PH_PORT_DIG,
    PH_PATH,
    PH_FAIL
  } phase_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] scheme_cnt_r, scheme_cnt_nxt;
  logic [LEN_W-1:0] host_cnt_r, host_cnt_nxt;
  logic [16:0]      accum_r, accum_nxt;
  logic             neg_r, neg_nxt;
  logic             seen_port_r, seen_port_nxt;
  logic [LEN_W-1:0] path_off_r, path_off_nxt;
  logic [1:0]       sep_r, sep_nxt;
  logic             term_r, term_nxt;

  logic [7:0]  c;
  logic [3:0]  digit;
  logic [19:0] acc_x10;
  logic [16:0] acc_sat;
  logic        port_bad_cur;
  logic        port_bad_nxt;
  logic        ok;

  assign c       = item.char_byte;
  assign digit   = 4'(c - CH_ZERO);
  assign acc_x10 = {3'b000, accum_r} * 20'd10 + 20'(digit);
  assign acc_sat = (acc_x10 > 20'(PORT_SAT)) ? PORT_SAT : acc_x10[16:0];
  assign port_bad_cur = (neg_r && (accum_r != 17'd0)) || accum_r[16];

  // state after this byte, before the end-of-URL clear
  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    scheme_cnt_nxt = scheme_cnt_r;
    host_cnt_nxt   = host_cnt_r;
    accum_nxt      = accum_r;
    neg_nxt        = neg_r;
    seen_port_nxt  = seen_port_r;
    path_off_nxt   = path_off_r;
    sep_nxt        = sep_r;
    term_nxt       = term_r;

    // once failed nothing else matters, so bytes are simply dropped
    if (!term_r) begin
      if (c == 8'h00) begin
        term_nxt = 1'b1;
      end else if (phase_r != PH_FAIL) begin
        if (pos_r >= POS_MAX) begin
          phase_nxt = PH_FAIL;
        end else begin
          pos_nxt = pos_r + 1'b1;
          unique case (phase_r)
            PH_SCHEME: begin
              if (sep_r == 2'd2 && c == CH_SLASH) begin
                sep_nxt   = 2'd0;
                phase_nxt = PH_HOST;
              end else if (sep_r == 2'd1 && c == CH_SLASH) begin
                sep_nxt = 2'd2;
              end else if (sep_r != 2'd0) begin
                phase_nxt = PH_FAIL;
              end else if (c == CH_COLON) begin
                sep_nxt = 2'd1;
              end else begin
                if (scheme_cnt_r != CNT_SAT) begin
                  scheme_cnt_nxt = scheme_cnt_r + 1'b1;
                end
                if (!is_alnum(c) && c != CH_PLUS && c != CH_MINUS && c != CH_DOT) begin
                  phase_nxt = PH_FAIL;
                end
              end
            end
            PH_HOST: begin
              if (c == CH_COLON) begin
                seen_port_nxt = 1'b1;
                phase_nxt     = PH_PORT_START;
              end else if (c == CH_SLASH) begin
                path_off_nxt = pos_r[LEN_W-1:0];
                phase_nxt    = PH_PATH;
              end else if (host_cnt_r == CNT_SAT) begin
                phase_nxt = PH_FAIL;
              end else begin
                host_cnt_nxt = host_cnt_r + 1'b1;
                if (!is_alnum(c) && c != CH_MINUS && c != CH_DOT) begin
                  phase_nxt = PH_FAIL;
                end
              end
            end
            PH_PORT_START, PH_PORT_WS: begin
              if (c == CH_SLASH && phase_r == PH_PORT_START) begin
                path_off_nxt = pos_r[LEN_W-1:0];
                phase_nxt    = PH_PATH;
              end else if (is_space(c)) begin
                phase_nxt = PH_PORT_WS;
              end else if (c == CH_PLUS || c == CH_MINUS) begin
                neg_nxt   = (c == CH_MINUS);
                phase_nxt = PH_PORT_SIGN;
              end else if (is_digit(c)) begin
                accum_nxt = {13'd0, digit};
                phase_nxt = PH_PORT_DIG;
              end else begin
                phase_nxt = PH_FAIL;
              end
            end
            PH_PORT_SIGN: begin
              if (is_digit(c)) begin
                accum_nxt = {13'd0, digit};
                phase_nxt = PH_PORT_DIG;
              end else begin
                phase_nxt = PH_FAIL;
              end
            end
            PH_PORT_DIG: begin
              if (is_digit(c)) begin
                accum_nxt = acc_sat;
              end else if (c == CH_SLASH && !port_bad_cur) begin
                path_off_nxt = pos_r[LEN_W-1:0];
                phase_nxt    = PH_PATH;
              end else begin
                phase_nxt = PH_FAIL;
              end
            end
            PH_PATH: begin
            end
            default: begin
              phase_nxt = PH_FAIL;
            end
          endcase
        end
      end
    end
  end

  assign port_bad_nxt = (neg_nxt && (accum_nxt != 17'd0)) || accum_nxt[16];

  always_comb begin
    case (phase_nxt)
      PH_HOST, PH_PORT_START, PH_PATH: ok = 1'b1;
      PH_PORT_DIG:                     ok = !port_bad_nxt;
      default:                         ok = 1'b0;
    endcase
    if (host_cnt_nxt > host_limit) begin
      ok = 1'b0;
    end

    res = '0;
    if (ok) begin
      res.url_ok      = 1'b1;
      res.scheme_len  = scheme_cnt_nxt;
      res.host_len    = host_cnt_nxt;
      res.port_given  = seen_port_nxt;
      res.port_number = seen_port_nxt ? accum_nxt[PORT_W-1:0] : '0;
      res.path_given  = (phase_nxt == PH_PATH);
      res.path_start  = (phase_nxt == PH_PATH) ? path_off_nxt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (consume && item.is_last)) begin
      phase_r      <= PH_SCHEME;
      pos_r        <= '0;
      scheme_cnt_r <= '0;
      host_cnt_r   <= '0;
      accum_r      <= '0;
      neg_r        <= 1'b0;
      seen_port_r  <= 1'b0;
      path_off_r   <= '0;
      sep_r        <= 2'd0;
      term_r       <= 1'b0;
    end else if (consume) begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      scheme_cnt_r <= scheme_cnt_nxt;
      host_cnt_r   <= host_cnt_nxt;
      accum_r      <= accum_nxt;
      neg_r        <= neg_nxt;
      seen_port_r  <= seen_port_nxt;
      path_off_r   <= path_off_nxt;
      sep_r        <= sep_nxt;
      term_r       <= term_nxt;
    end
  end

endmodule : uap_parse

`default_nettype wire

@@ sv/uap_out_stage.sv @@
// Result register driving the output channel.
`default_nettype none

module uap_out_stage
  import uap_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire res_t res,
  output logic      free,
  uap_out_if.source out_chan
);

  logic vld_r;
  res_t res_r;

  assign free = !vld_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (free) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      res_r <= res;
    end
  end

  assign out_chan.valid       = vld_r;
  assign out_chan.url_ok      = res_r.url_ok;
  assign out_chan.scheme_len  = res_r.scheme_len;
  assign out_chan.host_len    = res_r.host_len;
  assign out_chan.port_given  = res_r.port_given;
  assign out_chan.port_number = res_r.port_number;
  assign out_chan.path_given  = res_r.path_given;
  assign out_chan.path_start  = res_r.path_start;

endmodule : uap_out_stage

`default_nettype wire
